/* hdl/tew_pkg.sv */
// shared types, constants and the fixed weight table codes
`default_nettype none
package tew_pkg;

  localparam int REG_BITS        = 20;
  localparam int STRESS_BITS_DEF = 24;
  localparam int WEIGHT_FRAC_DEF = 16;
  localparam int LANES           = 3;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [REG_BITS-1:0] TENSILE_RESET     = REG_BITS'(3000);
  localparam logic [REG_BITS-1:0] COMPRESSIVE_RESET = REG_BITS'(30000);
  localparam logic [REG_BITS-1:0] LIMIT_RESET       = REG_BITS'(10000);

  typedef enum logic [1:0] {
    REG_TENSILE     = 2'd0,
    REG_COMPRESSIVE = 2'd1,
    REG_LIMIT       = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    BAND_TENSILE = 2'd0,
    BAND_MID     = 2'd1,
    BAND_FAR     = 2'd2
  } band_t;

  typedef enum logic [1:0] {
    WC_ZERO  = 2'd0,
    WC_THIRD = 2'd1,
    WC_HALF  = 2'd2,
    WC_ONE   = 2'd3
  } wcode_t;

  typedef struct packed {
    logic [REG_BITS-1:0] tensile;
    logic [REG_BITS-1:0] compressive;
    logic [REG_BITS-1:0] limit;
  } cfg_t;

  typedef struct packed {
    logic  err;
    band_t band_low;
    band_t band_mid;
    band_t band_high;
  } item_ctrl_t;

  // indexed {m node, l node, k node}
  localparam wcode_t WEIGHT_CODES [64] = '{
    WC_THIRD, WC_THIRD, WC_ZERO,  WC_ZERO,  WC_THIRD, WC_THIRD, WC_ZERO, WC_ZERO,
    WC_HALF,  WC_HALF,  WC_ZERO,  WC_ZERO,  WC_HALF,  WC_HALF,  WC_ZERO, WC_ZERO,
    WC_THIRD, WC_THIRD, WC_ZERO,  WC_ZERO,  WC_THIRD, WC_THIRD, WC_ZERO, WC_ZERO,
    WC_HALF,  WC_HALF,  WC_ZERO,  WC_ZERO,  WC_HALF,  WC_HALF,  WC_ZERO, WC_ZERO,
    WC_HALF,  WC_HALF,  WC_ZERO,  WC_ZERO,  WC_HALF,  WC_HALF,  WC_ZERO, WC_ZERO,
    WC_ONE,   WC_ONE,   WC_THIRD, WC_ZERO,  WC_ONE,   WC_ONE,   WC_HALF, WC_ZERO,
    WC_HALF,  WC_HALF,  WC_ZERO,  WC_ZERO,  WC_HALF,  WC_HALF,  WC_ZERO, WC_ZERO,
    WC_ONE,   WC_ONE,   WC_HALF,  WC_ZERO,  WC_ONE,   WC_ONE,   WC_ONE,  WC_THIRD
  };

endpackage
`default_nettype wire

/* hdl/triaxial_expansion_weights.sv */
// top level: configuration registers, front end, queue and blend pipeline
//
//  channel   | signals                                      | beat taken when
//  ----------+----------------------------------------------+------------------
//  input     | start, busy, stress_low/mid/high             | start && !busy
//  result    | done, weight_one/two/three, config_error     | done (one cycle)
//  config    | cfg_write, cfg_index, cfg_data               | cfg_write
//
//  one beat per cycle in and out; the strobe follows the accepting edge through
//  the one-bit-per-stage divider in the front end, the queue, then the table
//  lookup and the blend stages behind the queue.
//  synchronous reset empties all stages; config returns to its reset values.
//  the result side cannot stall, the queue drains every cycle and busy stays low.
`default_nettype none
module triaxial_expansion_weights #(
  parameter int STRESS_BITS      = tew_pkg::STRESS_BITS_DEF,
  parameter int WEIGHT_FRAC_BITS = tew_pkg::WEIGHT_FRAC_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic signed [STRESS_BITS-1:0]  stress_low,
  input  wire logic signed [STRESS_BITS-1:0]  stress_mid,
  input  wire logic signed [STRESS_BITS-1:0]  stress_high,
  input  wire logic                           cfg_write,
  input  wire logic [1:0]                     cfg_index,
  input  wire logic [tew_pkg::REG_BITS-1:0]   cfg_data,
  output logic                                done,
  output logic [WEIGHT_FRAC_BITS:0]           weight_one,
  output logic [WEIGHT_FRAC_BITS:0]           weight_two,
  output logic [WEIGHT_FRAC_BITS:0]           weight_three,
  output logic                                config_error
);
  import tew_pkg::*;

  localparam int TW = WEIGHT_FRAC_BITS + 1;
  localparam int QW = $bits(item_ctrl_t) + LANES * TW;

  cfg_t                cfg;
  logic                front_valid;
  item_ctrl_t          front_ctrl;
  logic [LANES*TW-1:0] front_t;
  logic                q_valid;
  logic [QW-1:0]       q_data;
  item_ctrl_t          back_ctrl;
  logic [LANES*TW-1:0] back_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{tensile: TENSILE_RESET, compressive: COMPRESSIVE_RESET, limit: LIMIT_RESET};
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_TENSILE:     cfg.tensile     <= cfg_data;
        REG_COMPRESSIVE: cfg.compressive <= cfg_data;
        REG_LIMIT:       cfg.limit       <= cfg_data;
        default: ;
      endcase
    end
  end

  tew_front #(
    .STRESS_BITS      (STRESS_BITS),
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (start && !busy),
    .stress_low  (stress_low),
    .stress_mid  (stress_mid),
    .stress_high (stress_high),
    .cfg         (cfg),
    .out_valid   (front_valid),
    .out_ctrl    (front_ctrl),
    .out_t       (front_t)
  );

  tew_queue #(
    .DATA_BITS (QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (front_valid),
    .push_data ({front_ctrl, front_t}),
    .pop       (q_valid),
    .full      (busy),
    .pop_valid (q_valid),
    .pop_data  (q_data)
  );

  assign {back_ctrl, back_t} = q_data;

  tew_back #(
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (q_valid),
    .in_ctrl      (back_ctrl),
    .in_t         (back_t),
    .done         (done),
    .weight_one   (weight_one),
    .weight_two   (weight_two),
    .weight_three (weight_three),
    .config_error (config_error)
  );

endmodule
`default_nettype wire

/* hdl/tew_front.sv */
// front end: band classification, clamping and pipelined restoring divide per stress
`default_nettype none
module tew_front #(
  parameter int STRESS_BITS      = tew_pkg::STRESS_BITS_DEF,
  parameter int WEIGHT_FRAC_BITS = tew_pkg::WEIGHT_FRAC_DEF
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst,
  input  wire logic                                        in_valid,
  input  wire logic signed [STRESS_BITS-1:0]               stress_low,
  input  wire logic signed [STRESS_BITS-1:0]               stress_mid,
  input  wire logic signed [STRESS_BITS-1:0]               stress_high,
  input  wire tew_pkg::cfg_t                               cfg,
  output logic                                             out_valid,
  output tew_pkg::item_ctrl_t                              out_ctrl,
  output logic [tew_pkg::LANES*(WEIGHT_FRAC_BITS+1)-1:0]   out_t
);
  import tew_pkg::*;

  localparam int SW = ((STRESS_BITS > REG_BITS) ? STRESS_BITS : REG_BITS) + 2;
  localparam int QB = WEIGHT_FRAC_BITS + 2;
  localparam int TW = WEIGHT_FRAC_BITS + 1;

  logic [STRESS_BITS-1:0] stress_in [LANES];
  logic signed [SW-1:0]   node_ts, node_sl, node_cs;
  band_t                  band_c [LANES];
  logic [REG_BITS-1:0]    num_c  [LANES];
  logic [REG_BITS-1:0]    den_c  [LANES];

  logic                   vld [0:QB];
  item_ctrl_t             ctl [0:QB];
  logic [REG_BITS-1:0]    rem [0:QB][LANES];
  logic [REG_BITS-1:0]    den [0:QB][LANES];
  logic [QB-1:0]          quo [0:QB][LANES];
  logic                   zer [0:QB][LANES];

  assign stress_in[0] = stress_low;
  assign stress_in[1] = stress_mid;
  assign stress_in[2] = stress_high;

  assign node_ts = $signed({{(SW-REG_BITS){1'b0}}, cfg.tensile});
  assign node_sl = -$signed({{(SW-REG_BITS){1'b0}}, cfg.limit});
  assign node_cs = -$signed({{(SW-REG_BITS){1'b0}}, cfg.compressive});

  always_comb begin
    logic signed [SW-1:0] s, hi, lo, sc, df;
    for (int j = 0; j < LANES; j++) begin
      s = $signed({{(SW-STRESS_BITS){stress_in[j][STRESS_BITS-1]}}, stress_in[j]});
      priority if (s > 0) begin
        band_c[j] = BAND_TENSILE;
        hi        = node_ts;
        lo        = '0;
        den_c[j]  = cfg.tensile;
      end else if (s > node_sl) begin
        band_c[j] = BAND_MID;
        hi        = '0;
        lo        = node_sl;
        den_c[j]  = cfg.limit;
      end else begin
        band_c[j] = BAND_FAR;
        hi        = node_sl;
        lo        = node_cs;
        den_c[j]  = cfg.compressive - cfg.limit;
      end
      sc = s;
      if (sc > hi) sc = hi;
      if (sc < lo) sc = lo;
      df = hi - sc;
      num_c[j] = df[REG_BITS-1:0];
    end
  end

  function automatic logic step_take(logic [REG_BITS-1:0] r, logic [REG_BITS-1:0] d,
                                     logic first);
    logic [REG_BITS:0] cmp;
    cmp = first ? {1'b0, r} : {r, 1'b0};
    return cmp >= {1'b0, d};
  endfunction

  function automatic logic [REG_BITS-1:0] step_rem(logic [REG_BITS-1:0] r,
                                                   logic [REG_BITS-1:0] d, logic first);
    logic [REG_BITS:0] cmp, dif;
    cmp = first ? {1'b0, r} : {r, 1'b0};
    dif = cmp - {1'b0, d};
    return (cmp >= {1'b0, d}) ? dif[REG_BITS-1:0] : cmp[REG_BITS-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= QB; k++) vld[k] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
      for (int k = 0; k < QB; k++) vld[k+1] <= vld[k];
    end
  end

  always_ff @(posedge clk) begin
    ctl[0] <= '{err: (cfg.compressive <= cfg.limit), band_low: band_c[0],
                band_mid: band_c[1], band_high: band_c[2]};
    for (int j = 0; j < LANES; j++) begin
      rem[0][j] <= num_c[j];
      den[0][j] <= den_c[j];
      quo[0][j] <= '0;
      zer[0][j] <= (den_c[j] == '0);
    end
    // one quotient bit per stage, remainder stays below the span
    for (int k = 0; k < QB; k++) begin
      ctl[k+1] <= ctl[k];
      for (int j = 0; j < LANES; j++) begin
        rem[k+1][j] <= step_rem(rem[k][j], den[k][j], k == 0);
        quo[k+1][j] <= {quo[k][j][QB-2:0], step_take(rem[k][j], den[k][j], k == 0)};
        den[k+1][j] <= den[k][j];
        zer[k+1][j] <= zer[k][j];
      end
    end
  end

  // quotient carries one extra bit, rounded half up here
  always_comb begin
    logic [QB-1:0] sum;
    for (int j = 0; j < LANES; j++) begin
      sum = quo[QB][j] + QB'(1);
      out_t[j*TW +: TW] = zer[QB][j] ? '0 : sum[QB-1:1];
    end
  end

  assign out_valid = vld[QB];
  assign out_ctrl  = ctl[QB];

endmodule
`default_nettype wire

/* hdl/tew_queue.sv */
// small fifo between front end and blend pipeline
`default_nettype none
module tew_queue #(
  parameter int DATA_BITS = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire logic [DATA_BITS-1:0] push_data,
  input  wire logic                 pop,
  output logic                      full,
  output logic                      pop_valid,
  output logic [DATA_BITS-1:0]      pop_data
);
  import tew_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_BITS-1:0] mem [QUEUE_DEPTH];
  logic [PW-1:0]        wr_ptr, rd_ptr;
  logic [CW-1:0]        count;
  logic                 do_push, do_pop;

  assign pop_valid = (count != '0);
  assign full      = (count == CW'(QUEUE_DEPTH));
  assign do_pop    = pop && pop_valid;
  assign do_push   = push && (!full || do_pop);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + PW'(1);
      if (do_pop)  rd_ptr <= rd_ptr + PW'(1);
      if (do_push && !do_pop) count <= count + CW'(1);
      else if (do_pop && !do_push) count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

endmodule
`default_nettype wire

/* hdl/tew_back.sv */
// back end: table lookup and the three interpolation stages for all weights
`default_nettype none
module tew_back #(
  parameter int WEIGHT_FRAC_BITS = tew_pkg::WEIGHT_FRAC_DEF
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst,
  input  wire logic                                        in_valid,
  input  wire tew_pkg::item_ctrl_t                         in_ctrl,
  input  wire logic [tew_pkg::LANES*(WEIGHT_FRAC_BITS+1)-1:0] in_t,
  output logic                                             done,
  output logic [WEIGHT_FRAC_BITS:0]                        weight_one,
  output logic [WEIGHT_FRAC_BITS:0]                        weight_two,
  output logic [WEIGHT_FRAC_BITS:0]                        weight_three,
  output logic                                             config_error
);
  import tew_pkg::*;

  localparam int WF = WEIGHT_FRAC_BITS;
  localparam int TW = WF + 1;
  localparam int PW = 2 * TW + 2;
  localparam int AW = PW + 1;
  localparam logic [TW-1:0] W_ONE   = {1'b1, {WF{1'b0}}};
  localparam logic [TW-1:0] W_HALF  = {2'b01, {(WF-1){1'b0}}};
  localparam logic [TW-1:0] W_THIRD = TW'(((64'd1 << WF) + 64'd1) / 64'd3);

  function automatic logic [TW-1:0] code_value(wcode_t c);
    logic [TW-1:0] v;
    unique case (c)
      WC_ZERO:  v = '0;
      WC_THIRD: v = W_THIRD;
      WC_HALF:  v = W_HALF;
      WC_ONE:   v = W_ONE;
      default:  v = '0;
    endcase
    return v;
  endfunction

  // a + (b - a) * t, rounded half up; one multiplier
  function automatic logic [TW-1:0] blend(logic [TW-1:0] a, logic [TW-1:0] b,
                                          logic [TW-1:0] t);
    logic signed [TW+1:0] ds, ts;
    logic signed [PW-1:0] prod;
    logic signed [AW-1:0] acc;
    ds   = $signed({2'b00, b}) - $signed({2'b00, a});
    ts   = $signed({2'b00, t});
    prod = PW'(ds * ts);
    acc  = $signed({{(AW-TW-WF){1'b0}}, a, {WF{1'b0}}}) + AW'(prod)
         + $signed({{(AW-TW){1'b0}}, W_HALF});
    return acc[WF +: TW];
  endfunction

  logic [1:0]    bnd  [LANES];
  logic [TW-1:0] tin  [LANES];

  assign bnd[0] = in_ctrl.band_low;
  assign bnd[1] = in_ctrl.band_mid;
  assign bnd[2] = in_ctrl.band_high;
  for (genvar j = 0; j < LANES; j++) begin : g_t
    assign tin[j] = in_t[j*TW +: TW];
  end

  logic          vld1, vld2, vld3, vld4;
  logic          err1, err2, err3, err4;
  logic [TW-1:0] ea1 [LANES][4];
  logic [TW-1:0] eb1 [LANES][4];
  logic [TW-1:0] tk1 [LANES], tl1 [LANES], tm1 [LANES];
  logic [TW-1:0] c2  [LANES][4];
  logic [TW-1:0] tl2 [LANES], tm2 [LANES];
  logic [TW-1:0] r3  [LANES][2];
  logic [TW-1:0] tm3 [LANES];
  logic [TW-1:0] w4  [LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
      vld4 <= 1'b0;
    end else begin
      vld1 <= in_valid;
      vld2 <= vld1;
      vld3 <= vld2;
      vld4 <= vld3;
    end
  end

  // weight w blends along stress w+2, then stress w, then stress w+1 (modulo three)
  for (genvar w = 0; w < LANES; w++) begin : g_weight
    localparam int KI = (w + 2) % 3;
    localparam int LI = w;
    localparam int MI = (w + 1) % 3;
    logic [1:0] rm [4];
    logic [1:0] rl [4];
    logic [1:0] kp;

    assign kp = bnd[KI] + 2'd1;
    for (genvar i = 0; i < 4; i++) begin : g_corner
      assign rm[i] = bnd[MI] + 2'(i >> 1);
      assign rl[i] = bnd[LI] + 2'(i & 1);
    end

    always_ff @(posedge clk) begin
      for (int i = 0; i < 4; i++) begin
        ea1[w][i] <= code_value(WEIGHT_CODES[{rm[i], rl[i], bnd[KI]}]);
        eb1[w][i] <= code_value(WEIGHT_CODES[{rm[i], rl[i], kp}]);
        c2[w][i]  <= blend(ea1[w][i], eb1[w][i], tk1[w]);
      end
      tk1[w]   <= tin[KI];
      tl1[w]   <= tin[LI];
      tm1[w]   <= tin[MI];
      tl2[w]   <= tl1[w];
      tm2[w]   <= tm1[w];
      r3[w][0] <= blend(c2[w][0], c2[w][1], tl2[w]);
      r3[w][1] <= blend(c2[w][2], c2[w][3], tl2[w]);
      tm3[w]   <= tm2[w];
      w4[w]    <= err3 ? '0 : blend(r3[w][0], r3[w][1], tm3[w]);
    end
  end

  always_ff @(posedge clk) begin
    err1 <= in_ctrl.err;
    err2 <= err1;
    err3 <= err2;
    err4 <= err3;
  end

  // stress order low, mid, high makes the first lane weight_three
  assign done         = vld4;
  assign config_error = err4;
  assign weight_three = w4[0];
  assign weight_one   = w4[1];
  assign weight_two   = w4[2];

endmodule
`default_nettype wire

/* hdl/tew_checker.sv */
// port-level checks on the top level, bound in below
`default_nettype none
module tew_checker #(
  parameter int WEIGHT_FRAC_BITS = tew_pkg::WEIGHT_FRAC_DEF
) (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic                        done,
  input wire logic [WEIGHT_FRAC_BITS:0]   weight_one,
  input wire logic [WEIGHT_FRAC_BITS:0]   weight_two,
  input wire logic [WEIGHT_FRAC_BITS:0]   weight_three,
  input wire logic                        config_error
);
  localparam int LAT = WEIGHT_FRAC_BITS + 8;
  localparam logic [WEIGHT_FRAC_BITS:0] W_ONE = {1'b1, {WEIGHT_FRAC_BITS{1'b0}}};

  // each accepted beat yields its result after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("result missing after accepted beat");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without an accepted beat");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && config_error) |-> (weight_one == '0 && weight_two == '0 && weight_three == '0))
    else $error("weights not zero on configuration error");

  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (weight_one <= W_ONE && weight_two <= W_ONE && weight_three <= W_ONE))
    else $error("weight above one");

  a_reset: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe after reset");

endmodule

bind triaxial_expansion_weights tew_checker #(
  .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
) u_tew_checker (.*);
`default_nettype wire
